### rtl/core/tth_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tth_pkg;

	localparam int TimeW = 24;
	localparam int BlockW = 64;
	localparam int KeyW = 64;

	// Config register indexes
	localparam logic CFG_KEY = 1'b0;
	localparam logic CFG_DEC = 1'b1;

	localparam logic [7:0] SwapBase = 8'd100;
	localparam logic [3:0] MaxDigit = 4'd9;
	localparam logic [3:0] DigitBase = 4'd10;
	localparam logic [4:0] Mod5 = 5'd5;

	// Sequencer states, one-hot
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PERM1 = 6'b000010,
		ST_ROUND = 6'b000100,
		ST_PERM2 = 6'b001000,
		ST_DEC   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	// Rotate a byte right by one
	function automatic logic [7:0] rot8r1(input logic [7:0] x);
		return {x[0], x[7:1]};
	endfunction

	// Bit reversal: position i of the result holds bit 63-i
	function automatic logic [63:0] rev64(input logic [63:0] x);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) begin
			r[i] = x[63 - i];
		end
		return r;
	endfunction

	// Remainder by five of a value below twenty
	function automatic logic [2:0] mod5(input logic [4:0] x);
		logic [4:0] y;
		y = x;
		for (int i = 0; i < 3; i++) begin
			if (y >= Mod5) begin
				y = y - Mod5;
			end
		end
		return y[2:0];
	endfunction

endpackage

`default_nettype wire

### rtl/core/token_time_hash_64.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Beat content
// s_axis    in         tdata[23:0] time_count
// m_axis    out        tdata[63:0] code_out
// cfg       in         cfg_index (0 secret_key, 1 decimal_output), cfg_data
//
// A beat passes from idle through the first permutation (16 key-nibble groups),
// 256 round steps at one a cycle, the second permutation, in decimal mode the
// decimal step over 16 digits, and finally the done state.
// The permutation walks one bit move a cycle through a 64-bit scratch word.
// Reset sets key to zero and decimal mode on; no clearing pass.
// A new beat is taken in idle even while a result waits on m_axis; the finished
// result waits in the done state until the output register is free.

module token_time_hash_64 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // [23:0] time_count
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [63:0] m_axis_tdata,   // [63:0] code_out
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_data
);

	tth_pkg::state_t state_q;

	logic [tth_pkg::KeyW-1:0]   secret_key_q;
	logic                       dec_q;
	logic [tth_pkg::KeyW-1:0]   key_q;
	logic [tth_pkg::BlockW-1:0] data_q;
	logic [tth_pkg::BlockW-1:0] bits_q;
	logic [tth_pkg::BlockW-1:0] out_q;
	logic                       out_valid_q;

	logic       pass_q;
	logic [2:0] grp_q;
	logic [3:0] n_q;
	logic [5:0] m_q;
	logic [5:0] s_q;
	logic [1:0] r_q;
	logic [3:0] d_q;
	logic [2:0] c_q;

	// Handshakes
	logic out_load;
	assign s_axis_tready = (state_q == tth_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_q;
	assign out_load = (state_q == tth_pkg::ST_DONE) && (!out_valid_q || m_axis_tready);

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secret_key_q <= '0;
			dec_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				tth_pkg::CFG_KEY: secret_key_q <= cfg_data;
				tth_pkg::CFG_DEC: dec_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input block: t2,t1,t0,t0 twice
	logic [31:0] half;
	logic [63:0] v_in;
	assign half = {s_axis_tdata[23:16], s_axis_tdata[15:8], s_axis_tdata[7:0],
		s_axis_tdata[7:0]};
	assign v_in = {half, half};

	// Permutation addressing
	logic [3:0] nib;
	logic [5:0] gb;
	logic [5:0] dst;
	logic [5:0] src [4];
	logic       perm_last;
	assign nib = key_q[{~{pass_q, grp_q}, 2'b00} +: 4];
	assign gb = {~pass_q, ~grp_q, 2'b00};
	assign dst = gb + m_q + 6'd4;
	assign perm_last = ({pass_q, grp_q} == 4'hF);
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			src[i] = gb + m_q + 6'(i);
		end
	end

	// Round step
	logic [7:0]  b0, b4, nb0, nb4, rt;
	logic [63:0] w, vn;
	always_comb begin
		b0 = data_q[63:56];
		b4 = data_q[31:24];
		rt = tth_pkg::rot8r1(b0) - 8'd1;
		if (key_q[s_q] ^ b0[7]) begin
			nb0 = b4;
			nb4 = tth_pkg::SwapBase - b0;
		end else begin
			nb0 = (tth_pkg::rot8r1(rt) - 8'd1) ^ b4;
			nb4 = b4;
		end
		w = {nb0, data_q[55:32], nb4, data_q[23:0]};
		vn = {w[62:0], w[63]};
	end

	// Decimal step
	logic [2:0] cn;
	logic [3:0] dig, dt, dn;
	always_comb begin
		cn = tth_pkg::mod5({2'b00, c_q} + {1'b0, key_q[63:60]});
		dig = data_q[63:60];
		dt = dig - {cn + 3'd1, 1'b0};
		dn = dig;
		if (dig > tth_pkg::MaxDigit) begin
			dn = (dt >= tth_pkg::DigitBase) ? dt - tth_pkg::DigitBase : dt;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tth_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			pass_q <= 1'b0;
			grp_q <= '0;
			n_q <= '0;
			m_q <= '0;
			s_q <= '0;
			r_q <= '0;
			d_q <= '0;
			c_q <= '0;
		end else begin
			// Output register: load a finished code or drop an accepted one
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				tth_pkg::ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= tth_pkg::ST_PERM1;
						pass_q <= 1'b0;
						grp_q <= '0;
						n_q <= '0;
						m_q <= '0;
					end
				end
				tth_pkg::ST_PERM1, tth_pkg::ST_PERM2: begin
					if (n_q != nib) begin
						n_q <= n_q + 4'd1;
						m_q <= m_q + 6'd1;
					end else begin
						n_q <= '0;
						{pass_q, grp_q} <= {pass_q, grp_q} + 4'd1;
						if (perm_last) begin
							if (state_q == tth_pkg::ST_PERM1) begin
								state_q <= tth_pkg::ST_ROUND;
								s_q <= 6'd63;
								r_q <= '0;
							end else if (dec_q) begin
								state_q <= tth_pkg::ST_DEC;
								d_q <= '0;
								c_q <= tth_pkg::mod5({1'b0, key_q[3:0]});
							end else begin
								state_q <= tth_pkg::ST_DONE;
							end
						end
					end
				end
				tth_pkg::ST_ROUND: begin
					s_q <= s_q - 6'd1;
					if (s_q == 6'd0) begin
						r_q <= r_q + 2'd1;
						if (r_q == 2'd3) begin
							state_q <= tth_pkg::ST_PERM2;
							m_q <= '0;
							n_q <= '0;
							pass_q <= 1'b0;
							grp_q <= '0;
						end
					end
				end
				tth_pkg::ST_DEC: begin
					d_q <= d_q + 4'd1;
					c_q <= cn;
					if (d_q == 4'hF) begin
						state_q <= tth_pkg::ST_DONE;
					end
				end
				tth_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= tth_pkg::ST_IDLE;
					end
				end
				default: state_q <= tth_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			tth_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					key_q <= secret_key_q;
					data_q <= v_in;
					bits_q <= tth_pkg::rev64(v_in);
				end
			end
			tth_pkg::ST_PERM1, tth_pkg::ST_PERM2: begin
				if (n_q != nib) begin
					bits_q[dst] <= bits_q[m_q];
				end else begin
					for (int i = 0; i < 4; i++) begin
						data_q[~(gb + 6'(i))] <= bits_q[src[i]];
					end
				end
			end
			tth_pkg::ST_ROUND: begin
				data_q <= vn;
				if (s_q == 6'd0) begin
					key_q <= key_q ^ vn;
					if (r_q == 2'd3) begin
						bits_q <= tth_pkg::rev64(vn);
					end
				end
			end
			tth_pkg::ST_DEC: begin
				data_q <= {data_q[59:0], dn};
				key_q <= {key_q[59:0], key_q[63:60]};
			end
			tth_pkg::ST_DONE: begin
				if (out_load) begin
					out_q <= data_q;
				end
			end
			default: ;
		endcase
	end

	// Checks
	a_accept_starts_perm: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == tth_pkg::ST_PERM1))
		else $error("accepted beat did not start the permutation");

	a_round_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tth_pkg::ST_ROUND && !(s_q == 6'd0 && r_q == 2'd3))
		|=> (state_q == tth_pkg::ST_ROUND))
		else $error("left the rounds early");

	a_dec_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tth_pkg::ST_DEC) |-> dec_q)
		else $error("decimal remap while disabled");

	a_move_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tth_pkg::ST_PERM1 || state_q == tth_pkg::ST_PERM2) |-> (n_q <= nib))
		else $error("bit move count overran key nibble");

endmodule

`default_nettype wire
